[design/pthc_pkg.sv]
package pthc_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned HW = DW / 2;

  localparam logic [1:0] ACT_TEMP  = 2'd0;
  localparam logic [1:0] ACT_PRESS = 2'd1;
  localparam logic [1:0] ACT_HUM   = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] REG_CALIB_TEMP    = 3'd0;
  localparam logic [2:0] REG_CALIB_PRESS_A = 3'd1;
  localparam logic [2:0] REG_CALIB_PRESS_B = 3'd2;
  localparam logic [2:0] REG_CALIB_PRESS_C = 3'd3;
  localparam logic [2:0] REG_CALIB_HUM     = 3'd4;

  typedef logic [DW-1:0] word64_t;
  typedef logic [31:0]   word32_t;

  function automatic word64_t sx16_64(input logic [15:0] v);
    sx16_64 = {{48{v[15]}}, v};
  endfunction

  function automatic word64_t sx32_64(input logic [31:0] v);
    sx32_64 = {{32{v[31]}}, v};
  endfunction

endpackage

[design/pthc_mul.sv]
// low 64 bits of a 64x64 product from one 32x32 unsigned multiplier
module pthc_mul import pthc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  word64_t a,
  input  word64_t b,
  output logic    done,
  output word64_t p
);

  word64_t      a_r, b_r, prod_r, acc_r;
  logic [1:0]   phase_r;
  logic         busy_r, done_r;
  logic [HW-1:0] opx, opy;
  word64_t      mul_out;

  always_comb begin
    case (phase_r)
      2'd1: begin
        opx = a_r[HW-1:0];
        opy = b_r[DW-1:HW];
      end
      2'd2: begin
        opx = a_r[DW-1:HW];
        opy = b_r[HW-1:0];
      end
      default: begin
        opx = a_r[HW-1:0];
        opy = b_r[HW-1:0];
      end
    endcase
  end

  assign mul_out = opx * opy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r     <= a;
        b_r     <= b;
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        case (phase_r)
          2'd0: prod_r <= mul_out;
          2'd1: begin
            acc_r  <= prod_r;
            prod_r <= mul_out;
          end
          2'd2: begin
            acc_r[DW-1:HW] <= acc_r[DW-1:HW] + prod_r[HW-1:0];
            prod_r         <= mul_out;
          end
          default: begin
            acc_r[DW-1:HW] <= acc_r[DW-1:HW] + prod_r[HW-1:0];
            busy_r         <= 1'b0;
            done_r         <= 1'b1;
          end
        endcase
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[design/pthc_div.sv]
// signed 64-bit divide, truncating, one quotient bit a cycle
module pthc_div import pthc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  word64_t num,
  input  word64_t den,
  output logic    done,
  output word64_t quo
);

  word64_t    a_r, b_r, rem_r, quo_r;
  logic [5:0] cnt_r;
  logic       busy_r, fin_r, done_r, neg_r;
  logic [DW:0] rem_sh, diff;

  assign rem_sh = {rem_r, a_r[DW-1]};
  assign diff   = rem_sh - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= num[DW-1] ? (word64_t'(0) - num) : num;
        b_r    <= den[DW-1] ? (word64_t'(0) - den) : den;
        neg_r  <= num[DW-1] ^ den[DW-1];
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[DW]) begin
          rem_r <= diff[DW-1:0];
          a_r   <= {a_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DW-1:0];
          a_r   <= {a_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        quo_r  <= neg_r ? (word64_t'(0) - a_r) : a_r;
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[design/pth_sensor_compensation_core.sv]
// fixed-point compensation for a pressure / temperature / humidity sensor.
// one raw reading comes in with an action (0 temperature, 1 pressure,
// 2 humidity) and one compensated word goes out: 0.01 degC, Pa*256 or %RH*1024.
// a temperature reading also refreshes the stored fine temperature used by the
// other two. all products run through one shared 32x32 multiplier (a 64-bit
// product is built from 32x32 partial products) and pressure uses a radix-2
// divider. action 3 gives a zero word. in_ready is high only between items; a
// new item may be taken while the last result still waits at the output.
// calibration is written through cfg_we / cfg_index / cfg_wdata; the user must
// write it only while idle, as the core itself does not enforce this.
module pth_sensor_compensation_core import pthc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [19:0] in_adc_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_value,
  output logic        out_div_zero,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_T1   = 5'd1;
  localparam logic [4:0] ST_T2   = 5'd2;
  localparam logic [4:0] ST_T3   = 5'd3;
  localparam logic [4:0] ST_TFIN = 5'd4;
  localparam logic [4:0] ST_P1   = 5'd5;
  localparam logic [4:0] ST_P2   = 5'd6;
  localparam logic [4:0] ST_P3   = 5'd7;
  localparam logic [4:0] ST_P4   = 5'd8;
  localparam logic [4:0] ST_P5   = 5'd9;
  localparam logic [4:0] ST_P6   = 5'd10;
  localparam logic [4:0] ST_P7   = 5'd11;
  localparam logic [4:0] ST_PDIV = 5'd12;
  localparam logic [4:0] ST_P8   = 5'd13;
  localparam logic [4:0] ST_P9   = 5'd14;
  localparam logic [4:0] ST_P10  = 5'd15;
  localparam logic [4:0] ST_PFIN = 5'd16;
  localparam logic [4:0] ST_H1   = 5'd17;
  localparam logic [4:0] ST_H2   = 5'd18;
  localparam logic [4:0] ST_H3   = 5'd19;
  localparam logic [4:0] ST_H4   = 5'd20;
  localparam logic [4:0] ST_H5   = 5'd21;
  localparam logic [4:0] ST_H6   = 5'd22;
  localparam logic [4:0] ST_H7   = 5'd23;
  localparam logic [4:0] ST_H8   = 5'd24;
  localparam logic [4:0] ST_OUT  = 5'd25;

  // calibration registers
  logic [47:0] calib_temp_r;
  word64_t     calib_press_a_r, calib_press_b_r, calib_hum_r;
  logic [15:0] calib_press_c_r;

  logic [4:0]  st_r;
  logic        wait_r;
  logic [1:0]  kind_r;
  logic [19:0] adc_r;
  word32_t     fine_r;
  word64_t     ta_r, tb_r, tc_r, td_r, te_r;
  word32_t     res_r;
  logic        dz_r;

  logic        out_valid_r, out_div_zero_r;
  logic [1:0]  out_kind_r;
  word32_t     out_value_r;

  // shared units
  logic    mul_start, mul_done, div_start, div_done;
  word64_t mul_a, mul_b, mul_p, div_q;
  word32_t m32;

  // coefficient fields
  word32_t t1, t2, t3;
  word64_t p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word32_t h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, calib_temp_r[15:0]};
  assign t2 = 32'(sx16_64(calib_temp_r[31:16]));
  assign t3 = 32'(sx16_64(calib_temp_r[47:32]));
  assign p1 = {48'd0, calib_press_a_r[15:0]};
  assign p2 = sx16_64(calib_press_a_r[31:16]);
  assign p3 = sx16_64(calib_press_a_r[47:32]);
  assign p4 = sx16_64(calib_press_a_r[63:48]);
  assign p5 = sx16_64(calib_press_b_r[15:0]);
  assign p6 = sx16_64(calib_press_b_r[31:16]);
  assign p7 = sx16_64(calib_press_b_r[47:32]);
  assign p8 = sx16_64(calib_press_b_r[63:48]);
  assign p9 = sx16_64(calib_press_c_r);
  assign h1 = {24'd0, calib_hum_r[7:0]};
  assign h2 = 32'(sx16_64(calib_hum_r[23:8]));
  assign h3 = {24'd0, calib_hum_r[31:24]};
  assign h4 = {20'd0, calib_hum_r[43:32]};
  assign h5 = {20'd0, calib_hum_r[55:44]};
  assign h6 = {{24{calib_hum_r[63]}}, calib_hum_r[63:56]};

  assign m32 = mul_p[31:0];

  // intermediate terms of the compensation formulas
  word32_t t_da, t_db, h_left, h_fin, h_clamp, t_out;
  word64_t p_s, p_num, p_sum, p_out, p_base;

  assign t_da   = 32'(adc_r >> 3) - (t1 << 1);
  assign t_db   = 32'(adc_r >> 4) - t1;
  assign p_s    = word64_t'($signed(ta_r) >>> 13);
  assign p_base = word64_t'(1048576) - word64_t'(adc_r);
  assign p_num  = (p_base << 31) - tc_r;
  assign p_sum  = ta_r + tb_r + tc_r;
  assign p_out  = word64_t'($signed(p_sum) >>> 8) + (p7 << 4);
  assign h_left = word32_t'($signed((32'(adc_r[15:0]) << 14) - (h4 << 20) - m32
                  + 32'd16384) >>> 15);
  assign h_fin  = ta_r[31:0] - word32_t'($signed(m32) >>> 4);
  assign t_out  = word32_t'($signed((fine_r << 2) + fine_r + 32'd128) >>> 8);

  // humidity clamp to 0 .. 100 %RH in the q10.22 scale
  always_comb begin
    if (h_fin[31]) begin
      h_clamp = '0;
    end else if (h_fin > 32'd419430400) begin
      h_clamp = 32'd419430400;
    end else begin
      h_clamp = h_fin;
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    case (st_r)
      ST_T1: begin
        mul_a = {32'd0, t_da};
        mul_b = {32'd0, t2};
      end
      ST_T2: begin
        mul_a = {32'd0, t_db};
        mul_b = {32'd0, t_db};
      end
      ST_T3: begin
        mul_a = tb_r;
        mul_b = {32'd0, t3};
      end
      ST_P1: begin
        mul_a = ta_r;
        mul_b = ta_r;
      end
      ST_P2: begin
        mul_a = tb_r;
        mul_b = p6;
      end
      ST_P3: begin
        mul_a = ta_r;
        mul_b = p5;
      end
      ST_P4: begin
        mul_a = tb_r;
        mul_b = p3;
      end
      ST_P5: begin
        mul_a = ta_r;
        mul_b = p2;
      end
      ST_P6: begin
        mul_a = (word64_t'(1) << 47) + td_r;
        mul_b = p1;
      end
      ST_P7: begin
        mul_a = p_num;
        mul_b = word64_t'(3125);
      end
      ST_P8: begin
        mul_a = p9;
        mul_b = p_s;
      end
      ST_P9: begin
        mul_a = tb_r;
        mul_b = p_s;
      end
      ST_P10: begin
        mul_a = p8;
        mul_b = ta_r;
      end
      ST_H1: begin
        mul_a = {32'd0, h5};
        mul_b = ta_r;
      end
      ST_H2: begin
        mul_a = ta_r;
        mul_b = {32'd0, h6};
      end
      ST_H3: begin
        mul_a = ta_r;
        mul_b = {32'd0, h3};
      end
      ST_H4: begin
        mul_a = tc_r;
        mul_b = td_r;
      end
      ST_H5: begin
        mul_a = {32'd0, tc_r[31:0] + 32'd2097152};
        mul_b = {32'd0, h2};
      end
      ST_H6: begin
        mul_a = tb_r;
        mul_b = tc_r;
      end
      ST_H7: begin
        mul_a = {32'd0, word32_t'($signed(ta_r[31:0]) >>> 15)};
        mul_b = {32'd0, word32_t'($signed(ta_r[31:0]) >>> 15)};
      end
      ST_H8: begin
        mul_a = tb_r;
        mul_b = {32'd0, h1};
      end
      default: begin
        mul_a = ta_r;
        mul_b = tb_r;
      end
    endcase
  end

  // every multiply state except the divide issues one product
  assign mul_start = !wait_r && (st_r != ST_IDLE) && (st_r != ST_TFIN) &&
                     (st_r != ST_PDIV) && (st_r != ST_PFIN) && (st_r != ST_OUT);
  assign div_start = !wait_r && (st_r == ST_PDIV);

  pthc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  pthc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (td_r),
    .den   (te_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign in_ready = (st_r == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_temp_r    <= '0;
      calib_press_a_r <= '0;
      calib_press_b_r <= '0;
      calib_press_c_r <= '0;
      calib_hum_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CALIB_TEMP:    calib_temp_r    <= cfg_wdata[47:0];
        REG_CALIB_PRESS_A: calib_press_a_r <= cfg_wdata;
        REG_CALIB_PRESS_B: calib_press_b_r <= cfg_wdata;
        REG_CALIB_PRESS_C: calib_press_c_r <= cfg_wdata[15:0];
        REG_CALIB_HUM:     calib_hum_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wait_r      <= 1'b0;
      fine_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in ST_OUT the output register is handled below
      if (out_valid_r && out_ready && (st_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (mul_start || div_start) begin
        wait_r <= 1'b1;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r <= in_action;
            adc_r  <= in_adc_value;
            dz_r   <= 1'b0;
            res_r  <= '0;
            case (in_action)
              ACT_TEMP:  st_r <= ST_T1;
              ACT_PRESS: begin
                ta_r <= sx32_64(fine_r) - word64_t'(128000);
                st_r <= ST_P1;
              end
              ACT_HUM: begin
                ta_r <= {32'd0, fine_r - 32'd76800};
                st_r <= ST_H1;
              end
              default: st_r <= ST_OUT;
            endcase
          end
        end
        // temperature
        ST_T1: if (mul_done) begin
          ta_r   <= {32'd0, word32_t'($signed(m32) >>> 11)};
          wait_r <= 1'b0;
          st_r   <= ST_T2;
        end
        ST_T2: if (mul_done) begin
          tb_r   <= {32'd0, word32_t'($signed(m32) >>> 12)};
          wait_r <= 1'b0;
          st_r   <= ST_T3;
        end
        ST_T3: if (mul_done) begin
          fine_r <= ta_r[31:0] + word32_t'($signed(m32) >>> 14);
          wait_r <= 1'b0;
          st_r   <= ST_TFIN;
        end
        ST_TFIN: begin
          res_r <= t_out;
          st_r  <= ST_OUT;
        end
        // pressure
        ST_P1: if (mul_done) begin
          tb_r   <= mul_p;
          wait_r <= 1'b0;
          st_r   <= ST_P2;
        end
        ST_P2: if (mul_done) begin
          tc_r   <= mul_p;
          wait_r <= 1'b0;
          st_r   <= ST_P3;
        end
        ST_P3: if (mul_done) begin
          tc_r   <= tc_r + (mul_p << 17) + (p4 << 35);
          wait_r <= 1'b0;
          st_r   <= ST_P4;
        end
        ST_P4: if (mul_done) begin
          td_r   <= word64_t'($signed(mul_p) >>> 8);
          wait_r <= 1'b0;
          st_r   <= ST_P5;
        end
        ST_P5: if (mul_done) begin
          td_r   <= td_r + (mul_p << 12);
          wait_r <= 1'b0;
          st_r   <= ST_P6;
        end
        ST_P6: if (mul_done) begin
          te_r   <= word64_t'($signed(mul_p) >>> 33);
          wait_r <= 1'b0;
          // zero divisor: result forced to 0 and flagged
          if (word64_t'($signed(mul_p) >>> 33) == '0) begin
            dz_r <= 1'b1;
            st_r <= ST_OUT;
          end else begin
            st_r <= ST_P7;
          end
        end
        ST_P7: if (mul_done) begin
          td_r   <= mul_p;
          wait_r <= 1'b0;
          st_r   <= ST_PDIV;
        end
        ST_PDIV: if (div_done) begin
          ta_r   <= div_q;
          wait_r <= 1'b0;
          st_r   <= ST_P8;
        end
        ST_P8: if (mul_done) begin
          tb_r   <= mul_p;
          wait_r <= 1'b0;
          st_r   <= ST_P9;
        end
        ST_P9: if (mul_done) begin
          tb_r   <= word64_t'($signed(mul_p) >>> 25);
          wait_r <= 1'b0;
          st_r   <= ST_P10;
        end
        ST_P10: if (mul_done) begin
          tc_r   <= word64_t'($signed(mul_p) >>> 19);
          wait_r <= 1'b0;
          st_r   <= ST_PFIN;
        end
        ST_PFIN: begin
          res_r <= p_out[31:0];
          st_r  <= ST_OUT;
        end
        // humidity
        ST_H1: if (mul_done) begin
          tb_r   <= {32'd0, h_left};
          wait_r <= 1'b0;
          st_r   <= ST_H2;
        end
        ST_H2: if (mul_done) begin
          tc_r   <= {32'd0, word32_t'($signed(m32) >>> 10)};
          wait_r <= 1'b0;
          st_r   <= ST_H3;
        end
        ST_H3: if (mul_done) begin
          td_r   <= {32'd0, word32_t'($signed(m32) >>> 11) + 32'd32768};
          wait_r <= 1'b0;
          st_r   <= ST_H4;
        end
        ST_H4: if (mul_done) begin
          tc_r   <= {32'd0, word32_t'($signed(m32) >>> 10)};
          wait_r <= 1'b0;
          st_r   <= ST_H5;
        end
        ST_H5: if (mul_done) begin
          tc_r   <= {32'd0, word32_t'($signed(m32 + 32'd8192) >>> 14)};
          wait_r <= 1'b0;
          st_r   <= ST_H6;
        end
        ST_H6: if (mul_done) begin
          ta_r   <= {32'd0, m32};
          wait_r <= 1'b0;
          st_r   <= ST_H7;
        end
        ST_H7: if (mul_done) begin
          tb_r   <= {32'd0, word32_t'($signed(m32) >>> 7)};
          wait_r <= 1'b0;
          st_r   <= ST_H8;
        end
        ST_H8: if (mul_done) begin
          res_r  <= h_clamp >> 12;
          wait_r <= 1'b0;
          st_r   <= ST_OUT;
        end
        // hand the word over once the output register is free
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= kind_r;
            out_value_r    <= res_r;
            out_div_zero_r <= dz_r;
            st_r           <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_value    = out_value_r;
  assign out_div_zero = out_div_zero_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_dz_only_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_kind == ACT_PRESS && out_value == '0)
    else $error("divide-by-zero flag on a bad word");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ACT_NONE |-> out_value == '0 && !out_div_zero)
    else $error("unused action gave a non-zero word");

  a_mul_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> wait_r)
    else $error("multiplier finished with nothing outstanding");
`endif

endmodule

[test/pthc_checker.sv]
`timescale 1ns / 100ps

module pthc_checker import pthc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [19:0] in_adc_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_value,
  input  logic        out_div_zero,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          result_count,
  output int          divz_count
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        dz;
  } comp_word_t;

  comp_word_t  exp_words[$];
  logic [47:0] c_temp;
  logic [63:0] c_pa, c_pb, c_hum;
  logic [15:0] c_pc;
  logic [31:0] t_fine;

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] ext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [31:0] temp_comp(input logic [19:0] adc);
    logic [31:0] a, t1, t2, t3, v1, d, v2;
    a  = {12'd0, adc};
    t1 = {16'd0, c_temp[15:0]};
    t2 = {{16{c_temp[31]}}, c_temp[31:16]};
    t3 = {{16{c_temp[47]}}, c_temp[47:32]};
    v1 = sra32(((a >> 3) - (t1 << 1)) * t2, 11);
    d  = (a >> 4) - t1;
    v2 = sra32(sra32(d * d, 12) * t3, 14);
    t_fine = v1 + v2;
    return sra32(t_fine * 32'd5 + 32'd128, 8);
  endfunction

  function automatic logic [31:0] press_comp(input logic [19:0] adc, output logic dz);
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num, an, bn, q;
    p1 = {48'd0, c_pa[15:0]};
    p2 = ext16(c_pa[31:16]);  p3 = ext16(c_pa[47:32]);  p4 = ext16(c_pa[63:48]);
    p5 = ext16(c_pb[15:0]);   p6 = ext16(c_pb[31:16]);
    p7 = ext16(c_pb[47:32]);  p8 = ext16(c_pb[63:48]);  p9 = ext16(c_pc);
    v1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 0) begin
      dz = 1'b1;
      return 32'd0;
    end
    dz = 1'b0;
    p = 64'd1048576 - {44'd0, adc};
    num = ((p << 31) - v2) * 64'd3125;
    // truncating signed divide, most negative over minus one wraps
    an = num[63] ? -num : num;
    bn = v1[63] ? -v1 : v1;
    q = an / bn;
    p = (num[63] != v1[63]) ? -q : q;
    v1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
    v2 = sra64(p8 * p, 19);
    p = sra64(p + v1 + v2, 8) + (p7 << 4);
    return p[31:0];
  endfunction

  function automatic logic [31:0] hum_comp(input logic [19:0] adc);
    logic [31:0] h1, h2, h3, h4, h5, h6, a, x, l, r;
    h1 = {24'd0, c_hum[7:0]};
    h2 = {{16{c_hum[23]}}, c_hum[23:8]};
    h3 = {24'd0, c_hum[31:24]};
    h4 = {20'd0, c_hum[43:32]};
    h5 = {20'd0, c_hum[55:44]};
    h6 = {{24{c_hum[63]}}, c_hum[63:56]};
    a  = {16'd0, adc[15:0]};
    x  = t_fine - 32'd76800;
    l  = sra32((a << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    r  = sra32(sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768), 10);
    r  = sra32((r + 32'd2097152) * h2 + 32'd8192, 14);
    x  = l * r;
    x  = x - sra32(sra32(sra32(x, 15) * sra32(x, 15), 7) * h1, 4);
    if (x[31]) x = 32'd0;
    if (x > 32'd419430400) x = 32'd419430400;
    return x >> 12;
  endfunction

  int mism_shown;
  assign pending = exp_words.size();

  always_ff @(posedge clk) begin
    comp_word_t e, g;
    logic dzf;
    if (!rst_n) begin
      c_temp <= '0; c_pa <= '0; c_pb <= '0; c_pc <= '0; c_hum <= '0; t_fine = '0;
      exp_words.delete();
      fail_count <= 0; result_count <= 0; divz_count <= 0; mism_shown = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CALIB_TEMP:    c_temp <= cfg_wdata[47:0];
          REG_CALIB_PRESS_A: c_pa   <= cfg_wdata;
          REG_CALIB_PRESS_B: c_pb   <= cfg_wdata;
          REG_CALIB_PRESS_C: c_pc   <= cfg_wdata[15:0];
          REG_CALIB_HUM:     c_hum  <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        e.kind = in_action; e.dz = 1'b0; e.value = '0;
        case (in_action)
          ACT_TEMP:  e.value = temp_comp(in_adc_value);
          ACT_PRESS: begin
            e.value = press_comp(in_adc_value, dzf);
            e.dz = dzf;
          end
          ACT_HUM:   e.value = hum_comp(in_adc_value);
          default: ;
        endcase
        exp_words.push_back(e);
      end
      if (out_valid && out_ready) begin
        g = '{out_kind, out_value, out_div_zero};
        result_count <= result_count + 1;
        if (out_div_zero) divz_count <= divz_count + 1;
        if (exp_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mism_shown < 10) $display("unexpected word: %h", g);
          mism_shown++;
        end else begin
          e = exp_words.pop_front();
          if (g !== e) begin
            fail_count <= fail_count + 1;
            if (mism_shown < 10)
              $display("mismatch: exp kind %0d value %h dz %b, got kind %0d value %h dz %b",
                       e.kind, e.value, e.dz, g.kind, g.value, g.dz);
            mism_shown++;
          end
        end
      end
    end
  end

endmodule

[test/pth_sensor_compensation_core_tb.sv]
`timescale 1ns / 100ps

module pth_sensor_compensation_core_tb;
  import pthc_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_action;
  logic [19:0] in_adc_value;
  logic        out_valid, out_ready;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic        out_div_zero;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          fail_count, pending, result_count, divz_count;

  pth_sensor_compensation_core i_dut (.*);

  pthc_checker i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender state: words sent, and whether the receiver should hold off
  int  words_sent;
  logic hold_rx;
  int  idle_cycles;
  localparam int WATCHDOG = 20000;

  // receiver: random stall per word, plus a long hold-off when requested
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // watchdog on cycles with no word moving in either direction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays high into the next word when it follows with no gap
  task automatic send_word(input logic [1:0] act, input logic [19:0] adc, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_adc_value <= adc;
    @(posedge clk iff in_ready);
    words_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every word is back, then let the core settle before a write
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_adc();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom_range(0, 20'hFFFFF));
    endcase
  endfunction

  // plausible calibration around a typical part, with random spread
  task automatic write_typical_calib();
    write_reg(REG_CALIB_TEMP, 64'({16'($urandom_range(0, 100) - 50),
                                   16'(26000 + $urandom_range(0, 2000)),
                                   16'(27000 + $urandom_range(0, 2000))}));
    write_reg(REG_CALIB_PRESS_A, {16'(2800 + $urandom_range(0, 100)), 16'(3000 + $urandom_range(0, 200)),
                                  16'(-10700 + $urandom_range(0, 200)), 16'(36000 + $urandom_range(0, 2000))});
    write_reg(REG_CALIB_PRESS_B, {16'(3900 + $urandom_range(0, 200)), 16'(-10 + $urandom_range(0, 20)),
                                  16'(-7), 16'(140 + $urandom_range(0, 20))});
    write_reg(REG_CALIB_PRESS_C, 64'(16'(4285 + $urandom_range(0, 300))));
    write_reg(REG_CALIB_HUM, {8'h1e, 12'(50), 12'(310 + $urandom_range(0, 40)), 8'd0,
                              16'(360 + $urandom_range(0, 20)), 8'd75});
  endtask

  task automatic write_random_calib();
    write_reg(REG_CALIB_TEMP, {$urandom, $urandom});
    write_reg(REG_CALIB_PRESS_A, {$urandom, $urandom});
    write_reg(REG_CALIB_PRESS_B, {$urandom, $urandom});
    write_reg(REG_CALIB_PRESS_C, {$urandom, $urandom});
    write_reg(REG_CALIB_HUM, {$urandom, $urandom});
  endtask

  task automatic random_phase(input int n, input bit with_hold);
    logic [1:0] a;
    for (int i = 0; i < n; i++) begin
      // every fourth word is a temperature reading to seed fine temperature; the rest are random
      if (i % 4 == 0) a = ACT_TEMP;
      else if ($urandom_range(0, 19) == 0) a = ACT_NONE;
      else a = 2'($urandom_range(0, 2));
      if (with_hold && i == 10) hold_rx = 1'b1;
      send_word(a, rand_adc(), with_hold && i >= 10 && i < 30);
    end
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_action = ACT_TEMP; in_adc_value = '0;
    cfg_we = 1'b0; cfg_index = REG_CALIB_TEMP; cfg_wdata = '0;
    words_sent = 0; hold_rx = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero calibration: pressure divisor is zero
    send_word(ACT_PRESS, 20'h12345, 0);
    send_word(ACT_NONE, 20'hFFFFF, 0);
    send_word(ACT_TEMP, 20'h80000, 0);
    send_word(ACT_HUM, 20'hFFFFF, 0);
    drain();

    write_typical_calib();
    send_word(ACT_TEMP, 20'h7E000, 0);
    send_word(ACT_PRESS, 20'h50000, 0);
    send_word(ACT_HUM, 20'h06800, 0);
    // humidity upper bits must be ignored
    send_word(ACT_HUM, 20'hF6800, 0);
    send_word(ACT_TEMP, 20'h00000, 0);
    send_word(ACT_PRESS, 20'h00000, 0);
    send_word(ACT_HUM, 20'h00000, 0);
    send_word(ACT_TEMP, 20'hFFFFF, 0);
    send_word(ACT_PRESS, 20'hFFFFF, 0);
    send_word(ACT_HUM, 20'h0FFFF, 0);
    send_word(ACT_NONE, 20'h00000, 0);
    drain();

    // extreme coefficients
    write_reg(REG_CALIB_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CALIB_PRESS_A, 64'h8000_8000_8000_FFFF);
    write_reg(REG_CALIB_PRESS_B, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_CALIB_PRESS_C, 64'h8000);
    write_reg(REG_CALIB_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(ACT_TEMP, 20'hFFFFF, 0);
    send_word(ACT_PRESS, 20'h00000, 0);
    send_word(ACT_HUM, 20'h0FFFF, 0);
    send_word(ACT_TEMP, 20'h00000, 0);
    send_word(ACT_PRESS, 20'hFFFFF, 0);
    send_word(ACT_HUM, 20'h00000, 0);
    drain();

    write_typical_calib();
    random_phase(300, 1'b1);
    drain();
    write_random_calib();
    random_phase(150, 1'b0);
    drain();
    write_typical_calib();
    random_phase(300, 1'b0);
    drain();
    write_reg(REG_CALIB_PRESS_A, 64'h0);
    write_reg(REG_CALIB_TEMP, 64'h0);
    random_phase(100, 1'b0);
    drain();

    $display("%0d words sent, %0d results checked, %0d with zero divisor,",
             words_sent, result_count, divz_count);
    $display("over zero, typical, extreme and random calibration sets");
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
